@@ sv/rc4_keystream_generator_defines.svh @@
// ----------------------------------------------------------------------------
// rc4_keystream_generator_defines.svh
// Assertion macros for the RC4 keystream generator. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RC4_KEYSTREAM_GENERATOR_DEFINES_SVH
`define RC4_KEYSTREAM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RC4_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc4 assertion failed");
// next-cycle implication
`define RC4_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RC4_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ sv/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 keystream generator.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;

   // item op codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_GEN   = 2'd1;
   localparam logic [1:0] OP_IDENT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEN_J,
      ST_GEN_T,
      ST_GEN_W,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_I,
      ST_KS_WR_J
   } state_type;

   // control from the sequencer to the permutation store
   typedef struct packed {
      logic              clear;
      logic              we;
      logic [BYTE_W-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic [BYTE_W-1:0] raddr;
   } perm_req_type;

endpackage

@@ sv/rc4_keystream_generator.sv @@
// ----------------------------------------------------------------------------
// rc4_keystream_generator
// RC4-style keystream byte generator: seed load, key schedule, identity
// reset and keystream generation over a 256-entry permutation memory.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                        Handshake
// -------   ------------------------------------------   -------------------
// request   req_op req_data_byte req_last req_restart    start && !busy
// response  rsp_stream_byte                              rsp_strobe, 1 cycle
//
// Generate item (op 1): steps GEN_J, GEN_T and GEN_W with busy high,
//   and the registered result strobes after GEN_W. The steps come from three
//   dependent reads and two swap writes through the single read and write
//   port of the permutation RAM. Seed byte (op 0): with last set, a key
//   schedule follows, one step per entry, with busy high throughout.
// Identity reset (op 2) and unused op: handled in IDLE; busy stays low.
// Reset is synchronous; the permutation reads as identity right after reset
//   (valid bits, no clearing pass). The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "rc4_keystream_generator_defines.svh"

module rc4_keystream_generator #(
   parameter int SEED_MAX = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic       req_restart,
   output logic       rsp_strobe,
   output logic [7:0] rsp_stream_byte
);

   localparam int SEED_AW = (SEED_MAX > 1) ? $clog2(SEED_MAX) : 1;
   localparam int SLW     = $clog2(SEED_MAX + 1);

   // sequencer state
   rc4_pkg::state_type state_ff, state_in;

   // generator indices; j also serves as the key schedule's running j
   logic [7:0] i_ff, i_in;
   logic [7:0] j_ff, j_in;

   // key schedule step and seed index (step mod seed length)
   logic [7:0]         k_ff, k_in;
   logic [SEED_AW-1:0] kidx_ff, kidx_in;
   logic [SLW-1:0]     seed_len_ff, seed_len_in;

   // swap operands and output address
   logic [7:0] si_ff, si_in;
   logic [7:0] sj_ff, sj_in;
   logic [7:0] t_ff, t_in;

   // response register
   logic       rsp_strobe_ff, rsp_strobe_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;

   // memory ports
   rc4_pkg::perm_req_type perm_req;
   logic [7:0]            p_rd;
   logic                  seed_we;
   logic [SEED_AW-1:0]    seed_waddr;
   logic [7:0]            seed_rd;

   // scratch
   logic [7:0]     i_new;
   logic [7:0]     j_new;
   logic [SLW-1:0] kidx_next;

   rc4_perm u_perm (
      .clock   (clock),
      .reset   (reset),
      .req     (perm_req),
      .rd_data (p_rd)
   );

   // seed bytes; read address follows the key index every cycle
   rc4_ram #(
      .WIDTH (8),
      .DEPTH (SEED_MAX)
   ) u_seed (
      .clock (clock),
      .we    (seed_we),
      .waddr (seed_waddr),
      .wdata (req_data_byte),
      .raddr (kidx_ff),
      .rdata (seed_rd)
   );

   assign busy = (state_ff != rc4_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      kidx_in       = kidx_ff;
      seed_len_in   = seed_len_ff;
      si_in         = si_ff;
      sj_in         = sj_ff;
      t_in          = t_ff;
      rsp_strobe_in = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      perm_req      = '0;
      seed_we       = 1'b0;
      seed_waddr    = seed_len_ff[SEED_AW-1:0];
      i_new         = (req_restart ? 8'd0 : i_ff) + 8'd1;
      j_new         = 8'd0;
      kidx_next     = SLW'(kidx_ff) + SLW'(1);

      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (start) begin
               case (req_op)
                  rc4_pkg::OP_LOAD: begin
                     // bytes beyond capacity are dropped, length saturates
                     if (seed_len_ff < SLW'(SEED_MAX)) begin
                        seed_we     = 1'b1;
                        seed_len_in = seed_len_ff + SLW'(1);
                     end
                     if (req_last) begin
                        perm_req.clear = 1'b1;
                        j_in           = 8'd0;
                        k_in           = 8'd0;
                        kidx_in        = '0;
                        state_in       = rc4_pkg::ST_KS_RD_I;
                     end
                  end
                  rc4_pkg::OP_GEN: begin
                     // restart: indices start again from zero
                     i_in           = i_new;
                     j_in           = req_restart ? 8'd0 : j_ff;
                     perm_req.raddr = i_new;
                     state_in       = rc4_pkg::ST_GEN_J;
                  end
                  rc4_pkg::OP_IDENT: begin
                     perm_req.clear = 1'b1;
                     i_in           = 8'd0;
                     j_in           = 8'd0;
                     seed_len_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         rc4_pkg::ST_GEN_J: begin
            j_new          = j_ff + p_rd;
            si_in          = p_rd;
            j_in           = j_new;
            perm_req.raddr = j_new;
            state_in       = rc4_pkg::ST_GEN_T;
         end

         rc4_pkg::ST_GEN_T: begin
            // first half of the swap; output read issued alongside
            sj_in          = p_rd;
            perm_req.we    = 1'b1;
            perm_req.waddr = i_ff;
            perm_req.wdata = p_rd;
            t_in           = si_ff + p_rd;
            perm_req.raddr = si_ff + p_rd;
            state_in       = rc4_pkg::ST_GEN_W;
         end

         rc4_pkg::ST_GEN_W: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            // forward swapped entries; the RAM read saw pre-swap data
            if (t_ff == j_ff) begin
               rsp_byte_in = si_ff;
            end else if (t_ff == i_ff) begin
               rsp_byte_in = sj_ff;
            end else begin
               rsp_byte_in = p_rd;
            end
            rsp_strobe_in = 1'b1;
            state_in      = rc4_pkg::ST_IDLE;
         end

         rc4_pkg::ST_KS_RD_I: begin
            perm_req.raddr = k_ff;
            state_in       = rc4_pkg::ST_KS_RD_J;
         end

         rc4_pkg::ST_KS_RD_J: begin
            j_new          = j_ff + p_rd + seed_rd;
            si_in          = p_rd;
            j_in           = j_new;
            perm_req.raddr = j_new;
            state_in       = rc4_pkg::ST_KS_WR_I;
         end

         rc4_pkg::ST_KS_WR_I: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = k_ff;
            perm_req.wdata = p_rd;
            state_in       = rc4_pkg::ST_KS_WR_J;
         end

         rc4_pkg::ST_KS_WR_J: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            k_in           = k_ff + 8'd1;
            kidx_in        = (kidx_next == seed_len_ff) ? '0 : kidx_next[SEED_AW-1:0];
            if (k_ff == 8'hFF) begin
               seed_len_in = '0;
               i_in        = 8'd0;
               j_in        = 8'd0;
               state_in    = rc4_pkg::ST_IDLE;
            end else begin
               state_in    = rc4_pkg::ST_KS_RD_I;
            end
         end

         default: begin
            state_in = rc4_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rc4_pkg::ST_IDLE;
         i_ff          <= 8'd0;
         j_ff          <= 8'd0;
         k_ff          <= 8'd0;
         kidx_ff       <= '0;
         seed_len_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         kidx_ff       <= kidx_in;
         seed_len_ff   <= seed_len_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_stream_byte = rsp_byte_ff;

   // a result only ever follows the last generate step
   `RC4_ASSERT_IMP(a_strobe_after_gen, clock, reset, rsp_strobe, $past(state_ff == rc4_pkg::ST_GEN_W))
   // final seed byte starts the key schedule
   `RC4_ASSERT_NXT(a_last_starts_ks, clock, reset, start && !busy && req_op == rc4_pkg::OP_LOAD && req_last, state_ff == rc4_pkg::ST_KS_RD_I)
   // seed index wraps inside the loaded seed
   `RC4_ASSERT_IMP(a_kidx_in_seed, clock, reset, state_ff == rc4_pkg::ST_KS_RD_I, SLW'(kidx_ff) < seed_len_ff)

endmodule

@@ sv/rc4_ram.sv @@
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/rc4_perm.sv @@
// ----------------------------------------------------------------------------
// rc4_perm
// Permutation store: 256-byte RAM plus per-entry valid bits. An entry
// that is not valid reads as its own index, so identity needs only a clear.
// ----------------------------------------------------------------------------
module rc4_perm (
   input  logic                                clock,
   input  logic                                reset,
   input  rc4_pkg::perm_req_type               req,
   output logic [rc4_pkg::BYTE_W-1:0]          rd_data
);

   logic [rc4_pkg::PERM_DEPTH-1:0] vld_ff;
   logic [rc4_pkg::PERM_DEPTH-1:0] vld_in;
   logic                           vld_rd_ff;
   logic [rc4_pkg::BYTE_W-1:0]     raddr_ff;
   logic [rc4_pkg::BYTE_W-1:0]     ram_q;

   rc4_ram #(
      .WIDTH (rc4_pkg::BYTE_W),
      .DEPTH (rc4_pkg::PERM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (req.we),
      .waddr (req.waddr),
      .wdata (req.wdata),
      .raddr (req.raddr),
      .rdata (ram_q)
   );

   always_comb begin
      vld_in = vld_ff;
      if (req.clear) begin
         vld_in = '0;
      end else if (req.we) begin
         vld_in[req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // valid bit and address travel with the RAM read
   always_ff @(posedge clock) begin
      vld_rd_ff <= vld_ff[req.raddr];
      raddr_ff  <= req.raddr;
   end

   assign rd_data = vld_rd_ff ? ram_q : raddr_ff;

endmodule
